>>> rtl/core/bcpc_pkg.sv
// Package: curve points, gains and reciprocal constants for the charge curve lookup.
package bcpc_pkg;

  localparam int unsigned MvW     = 16;
  localparam int unsigned PctW    = 7;
  localparam int unsigned NumPoints = 13;
  localparam int unsigned IdxW    = $clog2(NumPoints + 1);
  localparam int unsigned OverW   = 7;   // offset inside a segment stays below 100
  localparam int unsigned GainW   = 5;   // rise scaled to a 100 mV step, at most 20
  localparam int unsigned ProdW   = OverW + GainW;
  localparam int unsigned RecipW  = 6;
  localparam int unsigned ScaledW = ProdW + RecipW;

  // floor(p / 100) == (p * 41) >> 12 for every p below 1000
  localparam logic [RecipW-1:0] RecipMul   = 6'd41;
  localparam int unsigned       RecipShift = 12;
  localparam int unsigned       QuotW      = 4;

  localparam logic [MvW-1:0] CurveMv [NumPoints] = '{
    16'd4200, 16'd4100, 16'd4000, 16'd3900, 16'd3850, 16'd3800, 16'd3750,
    16'd3700, 16'd3650, 16'd3600, 16'd3500, 16'd3400, 16'd3300
  };

  localparam logic [PctW-1:0] CurvePct [NumPoints] = '{
    7'd100, 7'd92, 7'd84, 7'd74, 7'd66, 7'd58, 7'd48,
    7'd40,  7'd30, 7'd22, 7'd12, 7'd5,  7'd0
  };

  // Percent rise from point k up to point k-1, scaled so every segment divides by 100.
  // The top point has no segment above it.
  localparam logic [GainW-1:0] CurveGain [NumPoints] = '{
    5'd0,  5'd8,  5'd8,  5'd10, 5'd16, 5'd16, 5'd20,
    5'd16, 5'd20, 5'd16, 5'd10, 5'd7,  5'd5
  };

endpackage

>>> rtl/core/bcpc_in_if.sv
// Interface: input channel carrying one cell voltage sample.
interface bcpc_in_if;
  import bcpc_pkg::*;

  logic           valid;
  logic           ready;
  logic [MvW-1:0] cell_millivolts;

  modport source (output valid, output cell_millivolts, input ready);
  modport sink   (input valid, input cell_millivolts, output ready);
endinterface

>>> rtl/core/bcpc_out_if.sv
// Interface: output channel carrying one charge estimate.
interface bcpc_out_if;
  import bcpc_pkg::*;

  logic            valid;
  logic            ready;
  logic [PctW-1:0] charge_percent;

  modport source (output valid, output charge_percent, input ready);
  modport sink   (input valid, input charge_percent, output ready);
endinterface

>>> rtl/core/battery_charge_percent_curve_core.sv
// Top level: three-stage pipelined voltage to charge percent curve lookup.
//
//  channel | dir | payload                  | transfer when
//  --------+-----+--------------------------+--------------------
//  in_i    | in  | cell_millivolts [15:0]   | valid & ready
//  out_o   | out | charge_percent  [6:0]    | valid & ready
//
// Three register stages; one sample enters every cycle unless the output
// stalls. Stage 1 picks the segment, stage 2 multiplies the offset by the
// segment gain, stage 3 divides by 100 with a reciprocal and adds the base
// percent. Reset clears the valid bits only. A stall at the output freezes
// every stage together and drops ready.
module battery_charge_percent_curve_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  bcpc_in_if.sink           in_i,
  bcpc_out_if.source        out_o
);
  import bcpc_pkg::*;

  logic                 advance;

  logic [NumPoints-1:0] below;
  logic [IdxW-1:0]      seg;
  logic [IdxW-1:0]      s1_idx_d;
  logic [OverW-1:0]     s1_over_d;
  logic [MvW-1:0]       diff;

  logic                 s1_valid_q;
  logic [IdxW-1:0]      s1_idx_q;
  logic [OverW-1:0]     s1_over_q;

  logic                 s2_valid_q;
  logic [ProdW-1:0]     s2_prod_q;
  logic [PctW-1:0]      s2_base_q;
  logic [ProdW-1:0]     s2_prod_d;

  logic                 s3_valid_q;
  logic [PctW-1:0]      s3_pct_q;
  logic [ScaledW-1:0]   scaled;
  logic [QuotW-1:0]     quot;
  logic [PctW-1:0]      s3_pct_d;

  // Move the whole pipe when the output slot is free or being taken.
  assign advance    = !s3_valid_q || out_o.ready;
  assign in_i.ready = advance;

  // Stage 1: locate the segment; the curve is descending so below[] is a thermometer code.
  always_comb begin
    for (int j = 0; j < NumPoints; j++) begin
      below[j] = in_i.cell_millivolts < CurveMv[j];
    end
    seg  = IdxW'($countones(below));
    diff = '0;
    if (seg == '0) begin
      s1_idx_d  = '0;
      s1_over_d = '0;
    end else if (seg == IdxW'(NumPoints)) begin
      s1_idx_d  = IdxW'(NumPoints - 1);
      s1_over_d = '0;
    end else begin
      s1_idx_d  = seg;
      diff      = in_i.cell_millivolts - CurveMv[seg];
      s1_over_d = diff[OverW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_idx_q  <= s1_idx_d;
      s1_over_q <= s1_over_d;
    end
  end

  // Stage 2: offset times gain.
  assign s2_prod_d = ProdW'(s1_over_q) * ProdW'(CurveGain[s1_idx_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_prod_q <= s2_prod_d;
      s2_base_q <= CurvePct[s1_idx_q];
    end
  end

  // Stage 3: truncating divide by 100 through the reciprocal, then add the base.
  assign scaled   = ScaledW'(s2_prod_q) * ScaledW'(RecipMul);
  assign quot     = scaled[RecipShift +: QuotW];
  assign s3_pct_d = s2_base_q + PctW'(quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_pct_q <= s3_pct_d;
    end
  end

  assign out_o.valid          = s3_valid_q;
  assign out_o.charge_percent = s3_pct_q;

`ifndef NO_ASSERTIONS
  // The top of the curve carries no offset.
  a_sat_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_idx_q == '0) |-> s1_over_q == '0)
    else $error("saturated segment with nonzero offset");

  // The reciprocal divide is exact only for products below 1000.
  a_prod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> s2_prod_q < ProdW'(1000))
    else $error("segment product out of reciprocal range");

  // A stall holds the inner stages in place.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !advance) |=> (s2_valid_q && $stable(s2_prod_q) && $stable(s2_base_q)))
    else $error("stage 2 changed during a stall");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> s3_pct_q <= PctW'(100))
    else $error("charge percent above 100");
`endif

endmodule

>>> bench/tb.sv
// Testbench: self-checking stimulus and scoreboard for the charge percent curve lookup.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcpc_pkg::MvW;
  import bcpc_pkg::PctW;

  localparam int unsigned Knees      = 13;
  localparam int unsigned EdgeItems  = 25;
  localparam int unsigned RandItems  = 400;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned TailCycles = 10;

  localparam int unsigned KneeMv [Knees] = '{
    4200, 4100, 4000, 3900, 3850, 3800, 3750, 3700, 3650, 3600, 3500, 3400, 3300
  };
  localparam int unsigned KneePct [Knees] = '{
    100, 92, 84, 74, 66, 58, 48, 40, 30, 22, 12, 5, 0
  };

  logic clk_i;
  logic rst_ni;

  bcpc_in_if  in_ch ();
  bcpc_out_if out_ch ();

  battery_charge_percent_curve_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  logic [MvW-1:0]  sample_q [$];
  bit              drain_q [$];
  logic [PctW-1:0] charge_q [$];

  int   error_count;
  int   sent_count;
  int   result_count;
  int   send_wait;
  int   recv_wait;
  logic hold_off;

  function automatic logic [PctW-1:0] charge_of_mv(logic [MvW-1:0] mv);
    int unsigned span;
    int unsigned rise;
    int unsigned over;
    if (mv >= KneeMv[0]) return PctW'(100);
    for (int k = 1; k < Knees; k++) begin
      if (mv >= KneeMv[k]) begin
        span = KneeMv[k-1] - KneeMv[k];
        rise = KneePct[k-1] - KneePct[k];
        over = mv - KneeMv[k];
        return PctW'(KneePct[k] + (over * rise) / span);
      end
    end
    return PctW'(0);
  endfunction

  // Idle gap for one item; every third stretch of 50 items runs without gaps.
  function automatic int draw_gap(int count);
    if ((count / 50) % 3 == 2) return 0;
    return $urandom_range(0, 4);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Sample driver
  always @(posedge clk_i or negedge rst_ni) begin : sample_drive
    logic offer_n;
    if (!rst_ni) begin
      in_ch.valid           <= 1'b0;
      in_ch.cell_millivolts <= '0;
      send_wait = 0;
    end else begin
      offer_n = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        charge_q.push_back(charge_of_mv(in_ch.cell_millivolts));
        sent_count++;
        send_wait = draw_gap(sent_count);
        offer_n   = 1'b0;
      end
      if (!offer_n && sample_q.size() > 0) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (!(drain_q[0] && charge_q.size() > 0)) begin
          // hold a marked sample back until every pending estimate is out
          in_ch.cell_millivolts <= sample_q.pop_front();
          void'(drain_q.pop_front());
          offer_n = 1'b1;
        end
      end
      in_ch.valid <= offer_n;
    end
  end

  // Estimate monitor and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin : charge_check
    logic            rdy_n;
    logic [PctW-1:0] want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      rdy_n = out_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (charge_q.size() == 0) begin
          $error("charge_percent: unexpected transfer, got %0d", out_ch.charge_percent);
          error_count++;
        end else begin
          want = charge_q.pop_front();
          if (out_ch.charge_percent !== want) begin
            $error("charge_percent: expected %0d, got %0d", want, out_ch.charge_percent);
            error_count++;
          end
        end
        result_count++;
        recv_wait = draw_gap(result_count);
        rdy_n     = 1'b0;
      end
      if (hold_off) begin
        rdy_n = 1'b0;
      end else if (!rdy_n) begin
        if (recv_wait > 0) recv_wait--;
        else rdy_n = 1'b1;
      end
      out_ch.ready <= rdy_n;
    end
  end

  // Long receiver stall while the sender keeps offering
  initial begin
    hold_off = 1'b0;
    wait (result_count >= 120);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("tb: done, errors");
    $finish;
  end

  initial begin : main_seq
    logic [MvW-1:0] edge_mv [EdgeItems];
    int             pick;
    edge_mv = '{
      16'd0, 16'd1, 16'd3299, 16'd3300, 16'd3301, 16'd3355, 16'd3400, 16'd3450,
      16'd3500, 16'd3600, 16'd3650, 16'd3700, 16'd3750, 16'd3800, 16'd3850,
      16'd3900, 16'd4000, 16'd4099, 16'd4100, 16'd4199, 16'd4200, 16'd4201,
      16'd32768, 16'd32767, 16'd65535
    };
    error_count  = 0;
    sent_count   = 0;
    result_count = 0;
    rst_ni                = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.cell_millivolts = '0;
    out_ch.ready          = 1'b0;

    foreach (edge_mv[i]) begin
      sample_q.push_back(edge_mv[i]);
      drain_q.push_back(1'b0);
    end
    for (int i = 0; i < RandItems; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) sample_q.push_back(MvW'($urandom_range(3250, 4250)));
      else if (pick < 8) sample_q.push_back(MvW'($urandom_range(0, 3300)));
      else sample_q.push_back(MvW'($urandom_range(0, 65535)));
      // pause the sender until the pipeline has drained
      drain_q.push_back(i == 60 || i == 250);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (sent_count == int'(EdgeItems + RandItems));
    wait (charge_q.size() == 0);
    repeat (TailCycles) @(posedge clk_i);

    if (error_count == 0 && charge_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      if (charge_q.size() != 0)
        $error("charge_percent: %0d estimates never arrived", charge_q.size());
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> battery_charge_percent_curve_core.f
rtl/core/bcpc_pkg.sv
rtl/core/bcpc_in_if.sv
rtl/core/bcpc_out_if.sv
rtl/core/battery_charge_percent_curve_core.sv
bench/tb.sv
